[rtl/sqlkw_pkg.sv]
// Shared types and keyword constants for the SQL keyword stream detector.
// No dependencies.
package sqlkw_pkg;

  localparam int HistDepth = 7;
  localparam int WinLen    = HistDepth + 1;
  localparam int KwCount   = 13;
  localparam int LenW      = $clog2(WinLen + 1);

  typedef logic [7:0] byte_t;

  // Byte 0 is the newest byte of the window, byte i is i beats back.
  typedef logic [WinLen-1:0][7:0]    win_t;
  typedef logic [HistDepth-1:0][7:0] hist_t;

  // String literals are right aligned, so the last character lands in byte 0.
  localparam win_t KwText [KwCount] = '{
    win_t'("drop "),
    win_t'("delete "),
    win_t'("insert "),
    win_t'("update "),
    win_t'("union "),
    win_t'("select "),
    win_t'("--"),
    win_t'(";--"),
    win_t'("/*"),
    win_t'("*/"),
    win_t'("xp_"),
    win_t'("exec "),
    win_t'("execute ")
  };

  localparam logic [LenW-1:0] KwLen [KwCount] = '{
    LenW'(5), LenW'(7), LenW'(7), LenW'(7), LenW'(6), LenW'(7), LenW'(2),
    LenW'(3), LenW'(2), LenW'(2), LenW'(3), LenW'(5), LenW'(8)
  };

endpackage

[rtl/sqlkw_match.sv]
// Parallel compare of the eight-byte window against every keyword tail.
// Depends on sqlkw_pkg.
module sqlkw_match (
  input  sqlkw_pkg::win_t win_i,
  output logic            hit_o
);
  import sqlkw_pkg::*;

  logic [KwCount-1:0] kw_hit;

  always_comb begin
    for (int k = 0; k < KwCount; k++) begin
      kw_hit[k] = 1'b1;
      for (int i = 0; i < WinLen; i++) begin
        if ((LenW'(i) < KwLen[k]) && (win_i[i] != KwText[k][i])) begin
          kw_hit[k] = 1'b0;
        end
      end
    end
  end

  assign hit_o = |kw_hit;

endmodule

[rtl/sql_keyword_stream_detector.sv]
// Top level of the SQL keyword stream detector: input register, history,
// sticky flag and result register. Depends on sqlkw_pkg and sqlkw_match.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------------------
//   in      | sink      | in_valid_i / in_stall_o  | text_byte_i[7:0], is_final_i
//   out     | source    | out_valid_o / out_stall_i| unsafe_o
//
// One byte beat per cycle is accepted while in_stall_o is low; the result of a final beat
// goes from the input register through the match into the result register.
// Reset clears history, flag and all valid bits.
// A stalled result holds only a final beat in the input register; other beats
// keep flowing since they produce no result.
module sql_keyword_stream_detector (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic is_final_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic unsafe_o
);
  import sqlkw_pkg::*;

  logic  s1_valid_q, s1_valid_d;
  byte_t s1_byte_q, s1_byte_d;
  logic  s1_final_q;
  hist_t hist_q, hist_d;
  logic  seen_q, seen_d;
  logic  out_valid_q, out_valid_d;
  logic  out_unsafe_q;

  logic  in_fire, s1_fire, out_free, hit, flag;
  win_t  win;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && (!s1_final_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  // fold A-Z to lower case
  always_comb begin
    s1_byte_d = text_byte_i;
    if (text_byte_i >= 8'h41 && text_byte_i <= 8'h5A) begin
      s1_byte_d = text_byte_i + 8'h20;
    end
  end

  assign win = {hist_q, s1_byte_q};

  sqlkw_match u_match (
    .win_i (win),
    .hit_o (hit)
  );

  assign flag = seen_q | hit;

  always_comb begin
    s1_valid_d  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
    hist_d      = hist_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (s1_fire) begin
      if (s1_final_q) begin
        hist_d      = '0;
        seen_d      = 1'b0;
        out_valid_d = 1'b1;
      end else begin
        hist_d = win[HistDepth-1:0];
        seen_d = flag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      hist_q      <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      hist_q      <= hist_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q  <= s1_byte_d;
      s1_final_q <= is_final_i;
    end
    if (s1_fire && s1_final_q) begin
      out_unsafe_q <= flag;
    end
  end

  assign out_valid_o = out_valid_q;
  assign unsafe_o    = out_unsafe_q;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_final_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked final beat");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_final_q) |=> (out_valid_q && hist_q == '0 && !seen_q))
    else $error("final beat did not clear state or post a result");

  a_seen_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seen_q && !(s1_fire && s1_final_q)) |=> seen_q)
    else $error("sticky flag dropped mid string");

  a_hit_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_final_q && hit) |=> out_unsafe_q)
    else $error("match on final beat not reported");

endmodule
